/* hw/rtl/pidci_pkg.sv */
package pidci_pkg;

  // Field widths.
  localparam int unsigned DATA_W  = 16;  // samples, gains, result
  localparam int unsigned CFG_W   = 15;  // divisor and integral limit
  localparam int unsigned ERR_W   = 17;  // measured minus target
  localparam int unsigned DIFF_W  = 18;  // error difference, multiplier operand A
  localparam int unsigned PROD_W  = DIFF_W + DATA_W;
  localparam int unsigned ACC_W   = PROD_W + 1;
  localparam int unsigned MAG_W   = PROD_W;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned IDX_W   = 3;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_GAIN_P   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I   = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D   = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIVISOR  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LIMIT    = 3'd4;

  // Reset values.
  localparam logic [CFG_W-1:0] DIVISOR_RESET = 15'd1;
  localparam logic [CFG_W-1:0] LIMIT_RESET   = 15'd10000;

  // Saturation bounds of the result magnitude.
  localparam logic [MAG_W-1:0] POS_MAX = MAG_W'(32767);
  localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(32768);
  localparam logic [DATA_W-1:0] SAT_POS = 16'h7fff;
  localparam logic [DATA_W-1:0] SAT_NEG = 16'h8000;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_MUL_P = 9'b000000100,
    S_MUL_I = 9'b000001000,
    S_MUL_D = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_DIVLD = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

endpackage

/* hw/rtl/pidci_mul.sv */
module pidci_mul (
  input  logic                                     clk,
  input  logic signed [pidci_pkg::DIFF_W-1:0]      a,
  input  logic signed [pidci_pkg::DATA_W-1:0]      b,
  output logic signed [pidci_pkg::PROD_W-1:0]      product
);

  // Registered signed multiply; the product is valid in the cycle after the operands.
  always_ff @(posedge clk) begin
    product <= pidci_pkg::PROD_W'(a * b);
  end

endmodule

/* hw/rtl/pidci_div.sv */
module pidci_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pidci_pkg::MAG_W-1:0]     dividend,
  input  logic [pidci_pkg::CFG_W-1:0]     divisor,
  output pidci_pkg::div_status_t          status,
  output logic [pidci_pkg::MAG_W-1:0]     quotient
);

  logic [pidci_pkg::CFG_W-1:0] rem;
  logic [pidci_pkg::CFG_W-1:0] dvs;
  logic [pidci_pkg::CNT_W-1:0] count;
  logic [pidci_pkg::CFG_W:0]   shifted;
  logic [pidci_pkg::CFG_W:0]   trial;
  logic                        fits;

  // One restoring step per cycle: shift in the next dividend bit and try the subtract.
  assign shifted = {rem, quotient[pidci_pkg::MAG_W-1]};
  assign trial   = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      count  <= '0;
    end else if (start) begin
      status.busy <= 1'b1;
      status.done <= 1'b0;
      count       <= pidci_pkg::CNT_W'(pidci_pkg::MAG_W);
    end else if (status.busy) begin
      count <= count - 1'b1;
      if (count == pidci_pkg::CNT_W'(1)) begin
        status.busy <= 1'b0;
        status.done <= 1'b1;
      end
    end else begin
      status.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (status.busy) begin
      rem      <= fits ? trial[pidci_pkg::CFG_W-1:0] : shifted[pidci_pkg::CFG_W-1:0];
      quotient <= {quotient[pidci_pkg::MAG_W-2:0], fits};
    end
  end

endmodule

/* hw/rtl/pid_controller_clamped_integral.sv */
// PID controller with a clamped integral term.
// Input channel: in_valid/in_ready carry one sample per beat, measured_value and
// target_value. Output channel: out_valid/out_ready carry one control_value per
// input beat, in order. Configuration: cfg_valid/cfg_ready write cfg_data into
// register cfg_index (0 proportional gain, 1 integral gain, 2 derivative gain,
// 3 divisor, 4 integral limit); other indexes are ignored. cfg_ready is always high.
// From the accepting edge to out_valid, each sample goes through sequencing
// with one shared 18x16 multiplier (state update, three products,
// accumulation), then the restoring divider, one quotient bit per cycle, then
// a step to pick up the finished quotient and one to saturate and load the
// output register.
// in_ready is high only while the sequencer is idle, so a new sample is not
// taken until the previous one has reached the output register.
// The result sits in its own output register, so the next sample is accepted
// while an earlier result still waits; if the receiver stalls, the finished
// result of the following sample waits inside the block until the register frees.
// Reset clears previous error and integral, sets all gains to zero, the divisor
// to one and the integral limit to 10000, and empties the output register.
module pid_controller_clamped_integral (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pidci_pkg::DATA_W-1:0]   measured_value,
  input  logic signed [pidci_pkg::DATA_W-1:0]   target_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pidci_pkg::DATA_W-1:0]   control_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pidci_pkg::IDX_W-1:0]           cfg_index,
  input  logic [pidci_pkg::DATA_W-1:0]          cfg_data
);

  pidci_pkg::state_t state;

  // Configuration registers.
  logic signed [pidci_pkg::DATA_W-1:0] gain_p;
  logic signed [pidci_pkg::DATA_W-1:0] gain_i;
  logic signed [pidci_pkg::DATA_W-1:0] gain_d;
  logic [pidci_pkg::CFG_W-1:0]         divisor;
  logic [pidci_pkg::CFG_W-1:0]         limit;

  // Controller state and per-sample working registers.
  logic signed [pidci_pkg::ERR_W-1:0]  prev_err;
  logic signed [pidci_pkg::DATA_W-1:0] integral;
  logic signed [pidci_pkg::ERR_W-1:0]  err;
  logic signed [pidci_pkg::DIFF_W-1:0] diff;
  logic signed [pidci_pkg::ACC_W-1:0]  acc;
  logic                                neg;

  // Shared multiplier operands and result.
  logic signed [pidci_pkg::DIFF_W-1:0] mul_a;
  logic signed [pidci_pkg::DATA_W-1:0] mul_b;
  logic signed [pidci_pkg::PROD_W-1:0] product;

  // Divider connections.
  logic                                div_start;
  logic [pidci_pkg::MAG_W-1:0]         div_dividend;
  logic [pidci_pkg::CFG_W-1:0]         div_divisor;
  pidci_pkg::div_status_t              div_status;
  logic [pidci_pkg::MAG_W-1:0]         quotient;

  // Integral update: add the error and clamp to the symmetric limit.
  logic signed [pidci_pkg::DIFF_W-1:0] int_sum;
  logic signed [pidci_pkg::DIFF_W-1:0] lim_pos;
  logic signed [pidci_pkg::DIFF_W-1:0] lim_neg;
  logic signed [pidci_pkg::DIFF_W-1:0] int_clamped;

  logic signed [pidci_pkg::ACC_W-1:0]  acc_next;
  logic [pidci_pkg::DATA_W-1:0]        result;
  logic                                out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == pidci_pkg::S_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign int_sum = {{2{integral[pidci_pkg::DATA_W-1]}}, integral}
                 + {err[pidci_pkg::ERR_W-1], err};
  assign lim_pos = {3'b000, limit};
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (int_sum < lim_neg) begin
      int_clamped = lim_neg;
    end else if (int_sum > lim_pos) begin
      int_clamped = lim_pos;
    end else begin
      int_clamped = int_sum;
    end
  end

  // Operand selection for the shared multiplier; each product lands in the cycle after its operands.
  always_comb begin
    unique case (state)
      pidci_pkg::S_MUL_P: begin
        mul_a = {err[pidci_pkg::ERR_W-1], err};
        mul_b = gain_p;
      end
      pidci_pkg::S_MUL_I: begin
        mul_a = {{2{integral[pidci_pkg::DATA_W-1]}}, integral};
        mul_b = gain_i;
      end
      pidci_pkg::S_MUL_D: begin
        mul_a = diff;
        mul_b = gain_d;
      end
      default: begin
        mul_a = diff;
        mul_b = gain_d;
      end
    endcase
  end

  assign acc_next = acc + {product[pidci_pkg::PROD_W-1], product};

  // The result is the negated sum over the divisor: divide the magnitude, then
  // apply the sign, which truncates toward zero.
  assign div_start    = (state == pidci_pkg::S_DIVLD);
  assign div_dividend = acc[pidci_pkg::ACC_W-1] ? pidci_pkg::MAG_W'(-acc)
                                                : pidci_pkg::MAG_W'(acc);
  assign div_divisor  = (divisor == '0) ? pidci_pkg::CFG_W'(1) : divisor;

  always_comb begin
    if (neg) begin
      result = (quotient > pidci_pkg::NEG_MAX) ? pidci_pkg::SAT_NEG
                                               : -quotient[pidci_pkg::DATA_W-1:0];
    end else begin
      result = (quotient > pidci_pkg::POS_MAX) ? pidci_pkg::SAT_POS
                                               : quotient[pidci_pkg::DATA_W-1:0];
    end
  end

  pidci_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  pidci_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_status),
    .quotient (quotient)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p  <= '0;
      gain_i  <= '0;
      gain_d  <= '0;
      divisor <= pidci_pkg::DIVISOR_RESET;
      limit   <= pidci_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pidci_pkg::REG_GAIN_P:  gain_p  <= cfg_data;
        pidci_pkg::REG_GAIN_I:  gain_i  <= cfg_data;
        pidci_pkg::REG_GAIN_D:  gain_d  <= cfg_data;
        pidci_pkg::REG_DIVISOR: divisor <= cfg_data[pidci_pkg::CFG_W-1:0];
        pidci_pkg::REG_LIMIT:   limit   <= cfg_data[pidci_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pidci_pkg::S_IDLE;
      prev_err  <= '0;
      integral  <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the output state the register is reloaded below instead.
      if (out_valid && out_ready && (state != pidci_pkg::S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pidci_pkg::S_IDLE: begin
          if (in_valid) begin
            state <= pidci_pkg::S_PREP;
          end
        end
        pidci_pkg::S_PREP: begin
          prev_err <= err;
          if (gain_i != '0) begin
            integral <= int_clamped[pidci_pkg::DATA_W-1:0];
          end
          state <= pidci_pkg::S_MUL_P;
        end
        pidci_pkg::S_MUL_P: state <= pidci_pkg::S_MUL_I;
        pidci_pkg::S_MUL_I: state <= pidci_pkg::S_MUL_D;
        pidci_pkg::S_MUL_D: state <= pidci_pkg::S_ACC;
        pidci_pkg::S_ACC:   state <= pidci_pkg::S_DIVLD;
        pidci_pkg::S_DIVLD: state <= pidci_pkg::S_DIV;
        pidci_pkg::S_DIV: begin
          if (div_status.done) begin
            state <= pidci_pkg::S_OUT;
          end
        end
        pidci_pkg::S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= pidci_pkg::S_IDLE;
          end
        end
        default: state <= pidci_pkg::S_IDLE;
      endcase
    end
  end

  // Working registers; these carry data only and need no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      pidci_pkg::S_IDLE: begin
        if (in_valid) begin
          err <= {measured_value[pidci_pkg::DATA_W-1], measured_value}
               - {target_value[pidci_pkg::DATA_W-1], target_value};
        end
      end
      pidci_pkg::S_PREP: begin
        diff <= {err[pidci_pkg::ERR_W-1], err} - {prev_err[pidci_pkg::ERR_W-1], prev_err};
        acc  <= '0;
      end
      pidci_pkg::S_MUL_I, pidci_pkg::S_MUL_D, pidci_pkg::S_ACC: begin
        acc <= acc_next;
      end
      pidci_pkg::S_DIVLD: begin
        neg <= !acc[pidci_pkg::ACC_W-1] && (acc != '0);
      end
      pidci_pkg::S_OUT: begin
        if (out_free) begin
          control_value <= result;
        end
      end
      default: ;
    endcase
  end

endmodule

/* tb/tb_pid_controller_clamped_integral.sv */
`timescale 1ns / 1ps

module tb_pid_controller_clamped_integral;
  import pidci_pkg::*;

  // Indexes at or above this count address no register, and writes to them are dropped.
  localparam int unsigned REG_COUNT = 5;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] measured_value = '0;
  logic signed [DATA_W-1:0] target_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] control_value;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  pid_controller_clamped_integral u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .measured_value (measured_value),
    .target_value   (target_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .control_value  (control_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Our own copy of the controller: gains, divisor, clamp bound and the two
  // pieces of loop state. They start at the reset values of the block.
  logic signed [DATA_W-1:0] gain_p_m = '0;
  logic signed [DATA_W-1:0] gain_i_m = '0;
  logic signed [DATA_W-1:0] gain_d_m = '0;
  logic [CFG_W-1:0]         divisor_m = DIVISOR_RESET;
  logic [CFG_W-1:0]         limit_m = LIMIT_RESET;
  logic signed [ERR_W-1:0]  prev_error_m = '0;
  logic signed [DATA_W-1:0] integral_m = '0;

  // Control values still owed by the block, oldest first.
  logic signed [DATA_W-1:0] expected_control[$];

  int failures = 0;
  // When clear, neither side inserts random gaps.
  bit idle_on = 1'b1;
  // Set by a test to make the receiver refuse beats for this many cycles.
  int rx_hold_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Reset is held at the start of the run and never again.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: far beyond the slowest legal run of the whole sequence.
  initial begin
    #10_000_000;
    $display("FAIL pid_controller_clamped_integral");
    $finish;
  end

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, 14)) : 0;
  endfunction

  // Mirrors a register write into the predictor. The 15-bit registers keep only
  // their low bits, so a write with bit 15 set is truncated just as in the block.
  function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                         input logic [DATA_W-1:0] data);
    case (idx)
      REG_GAIN_P:  gain_p_m = data;
      REG_GAIN_I:  gain_i_m = data;
      REG_GAIN_D:  gain_d_m = data;
      REG_DIVISOR: divisor_m = data[CFG_W-1:0];
      REG_LIMIT:   limit_m = data[CFG_W-1:0];
      default: ;
    endcase
  endfunction

  // Advances the controller state by one sample and returns the control value.
  // All arithmetic is done in 64 bits, so nothing wraps before the final
  // saturation. SystemVerilog division of signed operands truncates toward zero.
  function automatic logic signed [DATA_W-1:0] predict_control(
      input logic signed [DATA_W-1:0] meas, input logic signed [DATA_W-1:0] tgt);
    longint err, diff, acc, lim, dvs, sum, quo;
    err  = longint'(meas) - longint'(tgt);
    diff = err - longint'(prev_error_m);
    lim  = longint'(limit_m);
    dvs  = (divisor_m == '0) ? 64'sd1 : longint'(divisor_m);
    // A zero integral gain freezes the integral: no accumulation and no clamp.
    if (gain_i_m != 0) begin
      acc = longint'(integral_m) + err;
      if (acc < -lim) begin
        acc = -lim;
      end else if (acc > lim) begin
        acc = lim;
      end
      integral_m = acc[DATA_W-1:0];
    end
    prev_error_m = err[ERR_W-1:0];
    sum = err * longint'(gain_p_m) + longint'(integral_m) * longint'(gain_i_m)
        + diff * longint'(gain_d_m);
    quo = (-sum) / dvs;
    if (quo > 32767) begin
      quo = 32767;
    end else if (quo < -32768) begin
      quo = -32768;
    end
    return quo[DATA_W-1:0];
  endfunction

  // Offers one sample and returns in the time step of the accepting edge.
  // Valid is left high on return; the next call either replaces the payload in
  // that same step or lowers valid for its gap, so valid is never dropped and
  // raised again within one step.
  task automatic send_sample(input logic signed [DATA_W-1:0] meas,
                             input logic signed [DATA_W-1:0] tgt);
    int gap;
    gap = draw_gap();
    if (cfg_valid) begin
      cfg_valid <= 1'b0;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    measured_value <= meas;
    target_value   <= tgt;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    expected_control.push_back(predict_control(meas, tgt));
  endtask

  // The sender stops offering and waits for every owed result. Each sample
  // yields exactly one result, so an empty queue means the block is idle.
  task automatic wait_until_drained();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (expected_control.size() != 0) @(posedge clk);
  endtask

  // Register writes only happen with the block idle. Back-to-back writes keep
  // cfg_valid high; the next sample lowers it.
  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    wait_until_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    apply_register(idx, data);
  endtask

  task automatic write_gains(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                             input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] dvs,
                             input logic [DATA_W-1:0] lim);
    write_register(REG_GAIN_P, kp);
    write_register(REG_GAIN_I, ki);
    write_register(REG_GAIN_D, kd);
    write_register(REG_DIVISOR, dvs);
    write_register(REG_LIMIT, lim);
  endtask

  task automatic check_control(input logic signed [DATA_W-1:0] got);
    logic signed [DATA_W-1:0] want;
    if (expected_control.size() == 0) begin
      $display("%0t: control_value %0d arrived with no result expected", $time, got);
      failures++;
    end else begin
      want = expected_control.pop_front();
      if (got !== want) begin
        $display("%0t: control_value mismatch: expected %0d, actual %0d", $time, want, got);
        failures++;
      end
    end
  endtask

  // Receiver. Before each beat it either serves a long hold requested by a test
  // or draws a short random stall. While waiting with ready high it also watches
  // for a hold request, so a hold can start even when no result is pending.
  initial begin : result_receiver
    int stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else begin
        stall = draw_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1 && rx_hold_cycles == 0) @(posedge clk);
      if (out_valid === 1'b1) begin
        check_control(control_value);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return DATA_W'($urandom_range(0, 128) - 64);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Divisor draws include zero (written plain and as 16'h8000, both read as
  // one by the block) and 16'hffff, which truncates to the largest divisor.
  function automatic logic [DATA_W-1:0] rand_divisor();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h0001;
      3: return 16'h7fff;
      4: return 16'hffff;
      5: return DATA_W'($urandom_range(1, 64));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_limit();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return DATA_W'($urandom_range(1, 300));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_extreme();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd1;
      3: return 16'sd0;
      default: return 16'sd1;
    endcase
  endfunction

  // Mostly a process value close to its setpoint, as in a running loop, so the
  // integral walks inside its bounds; the rest is full-range or extreme noise or zero error.
  task automatic send_random_sample();
    int tgt, delta, meas;
    tgt = int'($signed(DATA_W'($urandom)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        delta = int'($urandom_range(0, 400)) - 200;
        meas = tgt + delta;
        if (meas > 32767) begin
          meas = 32767;
        end else if (meas < -32768) begin
          meas = -32768;
        end
        send_sample(DATA_W'(meas), DATA_W'(tgt));
      end
      6, 7: send_sample(DATA_W'($urandom), DATA_W'($urandom));
      8: send_sample(rand_extreme(), rand_extreme());
      default: send_sample(DATA_W'(tgt), DATA_W'(tgt));
    endcase
  endtask

  // With every gain at its reset value of zero the output must be zero, even
  // for the widest error.
  task automatic test_reset_defaults();
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
  endtask

  // Proportional term alone, driven into saturation in both directions.
  task automatic test_proportional_saturation();
    write_gains(16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'h7fff);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    write_register(REG_GAIN_P, 16'h7fff);
    send_sample(16'sd100, 16'sd0);
    send_sample(16'sd0, 16'sd0);
  endtask

  // A divisor of zero acts as one; odd quotients truncate toward zero for both
  // signs; the largest divisor shrinks the widest error to a small value.
  task automatic test_divisor();
    write_gains(16'h0001, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);
    send_sample(16'sd5, 16'sd12);
    write_register(REG_DIVISOR, 16'h7fff);
    send_sample(16'sh7fff, 16'sh8000);
    write_register(REG_DIVISOR, 16'h0003);
    send_sample(16'sd0, 16'sd7);
    write_register(REG_GAIN_P, 16'hffff);
    send_sample(16'sd0, 16'sd7);
  endtask

  // The integral climbs into a small bound, is pulled to zero by a zero bound,
  // saturates at the widest bound and then stays frozen while its gain is zero.
  task automatic test_integral_clamp();
    write_gains(16'h0000, 16'h0001, 16'h0000, 16'h0001, 16'h0005);
    send_sample(16'sd3, 16'sd0);
    send_sample(16'sd3, 16'sd0);
    send_sample(16'sd3, 16'sd0);
    send_sample(16'sd0, 16'sd20);
    write_register(REG_LIMIT, 16'h0000);
    send_sample(16'sd9, 16'sd0);
    write_register(REG_LIMIT, 16'hffff);
    write_register(REG_GAIN_I, 16'h8000);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000);
    write_register(REG_GAIN_I, 16'h0000);
    send_sample(16'sh8000, 16'sh7fff);
    write_register(REG_GAIN_I, 16'h0001);
    send_sample(16'sd0, 16'sd1);
  endtask

  // The difference term spans 18 bits when the error swings end to end.
  task automatic test_derivative_swing();
    write_gains(16'h0000, 16'h0000, 16'h7fff, 16'h0001, 16'h7fff);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
  endtask

  // Writes to indexes past the last register must leave every register alone.
  task automatic test_unknown_index();
    logic [IDX_W-1:0] idx;
    write_gains(16'h0003, 16'h0002, 16'hfffe, 16'h0007, 16'h0100);
    for (int i = REG_COUNT; i < (1 << IDX_W); i++) begin
      idx = IDX_W'(i);
      write_register(idx, 16'h5a5a);
    end
    send_sample(16'sd1234, 16'sd1000);
  endtask

  // Random phases, each with its own register setting. One phase runs with no
  // idling at all; two phases pin every register to an extreme.
  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      idle_on = (phase != 1);
      case (phase)
        2: write_gains(16'h8000, 16'h7fff, 16'h8000, 16'h0001, 16'h7fff);
        3: write_gains(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h0000);
        default: write_gains(rand_gain(), rand_gain(), rand_gain(), rand_divisor(),
                             rand_limit());
      endcase
      write_register(IDX_W'($urandom_range(REG_COUNT, (1 << IDX_W) - 1)), DATA_W'($urandom));
      for (int n = 0; n < 45; n++) begin
        send_random_sample();
      end
    end
    idle_on = 1'b1;
  endtask

  // The receiver refuses beats for a long stretch while samples keep coming
  // back to back, so the output register and the internal result both fill and
  // the block stops taking input.
  task automatic test_output_stall();
    write_gains(rand_gain(), rand_gain(), rand_gain(), rand_divisor(), rand_limit());
    idle_on = 1'b0;
    rx_hold_cycles = 400;
    for (int n = 0; n < 12; n++) begin
      send_random_sample();
    end
    idle_on = 1'b1;
  endtask

  // The sender goes quiet until every result is home, then resumes with the
  // loop state carried over.
  task automatic test_sender_pause();
    for (int n = 0; n < 10; n++) begin
      send_random_sample();
    end
    wait_until_drained();
    for (int n = 0; n < 10; n++) begin
      send_random_sample();
    end
  endtask

  initial begin : test_sequence
    while (rst !== 1'b0) @(posedge clk);
    @(posedge clk);
    test_reset_defaults();
    test_proportional_saturation();
    test_divisor();
    test_integral_clamp();
    test_derivative_swing();
    test_unknown_index();
    test_random_phases();
    test_output_stall();
    test_sender_pause();
    wait_until_drained();
    if (cfg_valid) begin
      cfg_valid <= 1'b0;
    end
    // Anything stray would show up in this window.
    repeat (60) @(posedge clk);
    if (failures == 0) begin
      $display("PASS pid_controller_clamped_integral");
    end else begin
      $display("FAIL pid_controller_clamped_integral");
    end
    $finish;
  end

endmodule
